// ===== hw/rtl/mme_pkg.sv =====
// Shared types and constants for the matrix multiply engine.
// Holds action and register codes, fixed field widths and the size struct.
// No dependencies.
`default_nettype none

package mme_pkg;

  // Action codes carried by an input item and by a queue entry
  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS_USED = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_COLS_USED = 2'd2;

  // Fixed field widths
  localparam int ACT_W       = 2;
  localparam int IDX_W       = 10;
  localparam int IN_ELEM_W   = 16;
  localparam int OUT_IDX_W   = 3;
  localparam int ACC_W       = 48;
  localparam int ROWS_W      = 4;
  localparam int INNER_W     = 11;
  localparam int COLS_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  // Register reset values
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 4'd8;
  localparam logic [INNER_W-1:0] INNER_RESET = 11'd784;
  localparam logic [COLS_W-1:0]  COLS_RESET  = 4'd8;

  // Command queue depth between front and back
  localparam int Q_DEPTH = 4;

  // Effective (clamped) matrix sizes
  typedef struct packed {
    logic [3:0]  rows;
    logic [12:0] inner;
    logic [3:0]  cols;
  } dims_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for both element stores. No dependencies.
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mme_queue.sv =====
// Short command queue between the front and back of the engine.
// Plain register FIFO; no package dependency.
`default_nettype none

module mme_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output logic                  empty,
  output logic                  full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mme_front.sv =====
// Front end: accepts input items, clamps sizes, checks load bounds and
// queues commands for the back end. Depends on mme_pkg.
`default_nettype none

module mme_front #(
  parameter int MAX_ROWS   = 8,
  parameter int MAX_INNER  = 1024,
  parameter int MAX_COLS   = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int QW         = 32
) (
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mme_pkg::ACT_W-1:0]       action,
  input  wire logic [mme_pkg::IDX_W-1:0]       row_index,
  input  wire logic [mme_pkg::IDX_W-1:0]       col_index,
  input  wire logic signed [mme_pkg::IN_ELEM_W-1:0] element_value,
  input  wire logic [mme_pkg::ROWS_W-1:0]      rows_used,
  input  wire logic [mme_pkg::INNER_W-1:0]     inner_len,
  input  wire logic [mme_pkg::COLS_W-1:0]      cols_used,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output logic [QW-1:0]                        q_data,
  output mme_pkg::dims_t                       dims
);
  import mme_pkg::*;

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AAW = RW + KW;
  localparam int BAW = KW + CW;
  localparam int AW  = (AAW > BAW) ? AAW : BAW;

  logic [3:0]            rows_eff;
  logic [12:0]           inner_eff;
  logic [3:0]            cols_eff;
  logic [ELEM_WIDTH-1:0] elem;
  logic                  a_ok;
  logic                  b_ok;
  logic [AW-1:0]         a_addr;
  logic [AW-1:0]         b_addr;
  logic                  keep;
  logic [AW-1:0]         cmd_addr;

  // Clamp sizes: zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (rows_used == '0) begin
      rows_eff = 4'd1;
    end else if (32'(rows_used) > 32'(MAX_ROWS)) begin
      rows_eff = 4'(MAX_ROWS);
    end else begin
      rows_eff = rows_used;
    end
    if (inner_len == '0) begin
      inner_eff = 13'd1;
    end else if (32'(inner_len) > 32'(MAX_INNER)) begin
      inner_eff = 13'(MAX_INNER);
    end else begin
      inner_eff = 13'(inner_len);
    end
    if (cols_used == '0) begin
      cols_eff = 4'd1;
    end else if (32'(cols_used) > 32'(MAX_COLS)) begin
      cols_eff = 4'(MAX_COLS);
    end else begin
      cols_eff = cols_used;
    end
  end

  assign dims = '{rows: rows_eff, inner: inner_eff, cols: cols_eff};

  // Sign-extend the element, then keep it at the stored width
  assign elem = ELEM_WIDTH'(32'(element_value));

  // Bounds checks and store addresses
  assign a_ok   = (32'(row_index) < 32'(rows_eff)) && (32'(col_index) < 32'(inner_eff));
  assign b_ok   = (32'(row_index) < 32'(inner_eff)) && (32'(col_index) < 32'(cols_eff));
  assign a_addr = AW'({RW'(row_index), KW'(col_index)});
  assign b_addr = AW'({KW'(row_index), CW'(col_index)});

  // Classify: drop out-of-range loads and unused actions
  always_comb begin
    unique case (action)
      ACT_LOAD_A: begin
        keep     = a_ok;
        cmd_addr = a_addr;
      end
      ACT_LOAD_B: begin
        keep     = b_ok;
        cmd_addr = b_addr;
      end
      ACT_START: begin
        keep     = 1'b1;
        cmd_addr = '0;
      end
      default: begin
        keep     = 1'b0;
        cmd_addr = '0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;
  assign q_data   = QW'({action, cmd_addr, elem});

endmodule

`default_nettype wire

// ===== hw/rtl/mme_back.sv =====
// Back end: drains the command queue, writes the element stores and runs
// the dot products with a result register. Depends on mme_pkg, mme_ram.
`default_nettype none

module mme_back #(
  parameter int MAX_ROWS   = 8,
  parameter int MAX_INNER  = 1024,
  parameter int MAX_COLS   = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int QW         = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_empty,
  input  wire logic [QW-1:0]                     q_head,
  output logic                                   q_pop,
  input  wire mme_pkg::dims_t                    dims,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [mme_pkg::OUT_IDX_W-1:0]          out_row,
  output logic [mme_pkg::OUT_IDX_W-1:0]          out_col,
  output logic signed [mme_pkg::ACC_W-1:0]       dot_sum,
  output logic                                   last
);
  import mme_pkg::*;

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AAW = RW + KW;
  localparam int BAW = KW + CW;
  localparam int AW  = (AAW > BAW) ? AAW : BAW;
  localparam int EW  = ELEM_WIDTH;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HOLD  = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]    state;
  logic [RW-1:0] i;
  logic [CW-1:0] j;
  logic [KW-1:0] k;

  logic [1:0]    cmd_kind;
  logic [AW-1:0] cmd_addr;
  logic [EW-1:0] cmd_data;

  logic          issue;
  logic          a_we;
  logic          b_we;
  logic [EW-1:0] a_rd;
  logic [EW-1:0] b_rd;

  logic i_last;
  logic j_last;
  logic k_last;

  logic                    s1_v;
  logic                    s1_first;
  logic                    s1_last;
  logic                    s2_v;
  logic                    s2_first;
  logic                    s2_last;
  logic signed [2*EW-1:0]  prod;
  logic signed [63:0]      prod_ext;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        sum;
  logic                    out_take;
  logic                    finish;

  // Unpack the queue head
  assign cmd_kind = q_head[QW-1 -: 2];
  assign cmd_addr = q_head[EW +: AW];
  assign cmd_data = q_head[EW-1:0];

  assign i_last = (i == RW'(dims.rows - 4'd1));
  assign j_last = (j == CW'(dims.cols - 4'd1));
  assign k_last = (k == KW'(dims.inner - 13'd1));

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign a_we  = q_pop && (cmd_kind == ACT_LOAD_A);
  assign b_we  = q_pop && (cmd_kind == ACT_LOAD_B);
  assign issue = (state == ST_ISSUE);

  mme_ram #(
    .WIDTH (EW),
    .DEPTH (2 ** AAW)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (cmd_addr[AAW-1:0]),
    .wr_data (cmd_data),
    .rd_en   (issue),
    .rd_addr ({i, k}),
    .rd_data (a_rd)
  );

  mme_ram #(
    .WIDTH (EW),
    .DEPTH (2 ** BAW)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (cmd_addr[BAW-1:0]),
    .wr_data (cmd_data),
    .rd_en   (issue),
    .rd_addr ({k, j}),
    .rd_data (b_rd)
  );

  // Accumulate: the first product of an element restarts the sum
  assign prod_ext = 64'(prod);
  assign sum      = (s2_first ? '0 : acc) + prod_ext[ACC_W-1:0];
  assign out_take = out_valid && !out_stall;
  assign finish   = (state == ST_DRAIN) && s2_v && s2_last;

  // Sequencer and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      if (out_take) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty && cmd_kind == ACT_START) begin
            i     <= '0;
            j     <= '0;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // wait for the result register to free up
          if (!out_valid || out_take) begin
            k     <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          k <= k + KW'(1);
          if (k_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (s2_v && s2_last) begin
            out_valid <= 1'b1;
            if (i_last && j_last) begin
              state <= ST_IDLE;
            end else begin
              if (j_last) begin
                j <= '0;
                i <= i + RW'(1);
              end else begin
                j <= j + CW'(1);
              end
              state <= ST_HOLD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: read, multiply, accumulate, capture result
  always_ff @(posedge clk) begin
    s1_first <= (k == '0);
    s1_last  <= k_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod     <= $signed(a_rd) * $signed(b_rd);
    if (s2_v) begin
      acc <= sum;
    end
    if (finish) begin
      out_row <= OUT_IDX_W'(i);
      out_col <= OUT_IDX_W'(j);
      dot_sum <= sum;
      last    <= i_last && j_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_multiply_engine_unit.sv =====
// Top level of the matrix multiply engine: configuration registers, front
// end, command queue and back end. Depends on mme_pkg and all mme_* modules.
//
// Usage:
//   Input channel (in_valid/in_stall): action selects load A, load B or
//   start. Loads write one element at row_index/col_index; loads outside
//   the configured sizes and unused actions are dropped. A start walks C in
//   row-major order and emits one result per element on the output channel
//   (out_valid/out_stall), with last set on the final element.
//   Inputs land in a four-entry command queue; in_stall rises only when the
//   queue is full. A load is written to its store in the cycle it leaves the
//   queue, so loads stream at one per cycle while no start is running.
//   For each C element the back end claims the result register, reads one
//   element pair per cycle from the two store RAMs, then passes the data
//   through the RAM read and multiplier stages.
//   When the receiver stalls, the finished result holds in the output
//   register and the next element waits for it to be taken.
//   Reset (rst, synchronous) empties the queue and the pipeline and sets
//   rows_used 8, inner_len 784, cols_used 8; the element stores are not
//   cleared. Write configuration only while the engine is idle.
`default_nettype none

module matrix_multiply_engine_unit #(
  parameter int MAX_ROWS   = 8,
  parameter int MAX_INNER  = 1024,
  parameter int MAX_COLS   = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [mme_pkg::ACT_W-1:0]             action,
  input  wire logic [mme_pkg::IDX_W-1:0]             row_index,
  input  wire logic [mme_pkg::IDX_W-1:0]             col_index,
  input  wire logic signed [mme_pkg::IN_ELEM_W-1:0]  element_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [mme_pkg::OUT_IDX_W-1:0]              out_row,
  output logic [mme_pkg::OUT_IDX_W-1:0]              out_col,
  output logic signed [mme_pkg::ACC_W-1:0]           dot_sum,
  output logic                                       last,
  input  wire logic                                  cfg_write_en,
  input  wire logic [mme_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [mme_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import mme_pkg::*;

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AAW = RW + KW;
  localparam int BAW = KW + CW;
  localparam int AW  = (AAW > BAW) ? AAW : BAW;
  localparam int QW  = ACT_W + AW + ELEM_WIDTH;

  logic [ROWS_W-1:0]  rows_used;
  logic [INNER_W-1:0] inner_len;
  logic [COLS_W-1:0]  cols_used;

  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_pop;
  logic [QW-1:0] q_head;
  logic          q_empty;
  logic          q_full;
  dims_t         dims;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= ROWS_RESET;
      inner_len <= INNER_RESET;
      cols_used <= COLS_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ROWS_USED: rows_used <= cfg_data[ROWS_W-1:0];
        REG_INNER_LEN: inner_len <= cfg_data[INNER_W-1:0];
        REG_COLS_USED: cols_used <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  mme_front #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_INNER  (MAX_INNER),
    .MAX_COLS   (MAX_COLS),
    .ELEM_WIDTH (ELEM_WIDTH),
    .QW         (QW)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .rows_used     (rows_used),
    .inner_len     (inner_len),
    .cols_used     (cols_used),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_push_data),
    .dims          (dims)
  );

  mme_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mme_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_INNER  (MAX_INNER),
    .MAX_COLS   (MAX_COLS),
    .ELEM_WIDTH (ELEM_WIDTH),
    .QW         (QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .dims      (dims),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .dot_sum   (dot_sum),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mme_checker.sv =====
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and matrix_multiply_engine_unit.
`default_nettype none

module mme_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_stall,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic [mme_pkg::OUT_IDX_W-1:0]         out_row,
  input wire logic [mme_pkg::OUT_IDX_W-1:0]         out_col,
  input wire logic signed [mme_pkg::ACC_W-1:0]      dot_sum,
  input wire logic                                  last
);

  // Reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result pending or input stalled after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dot_sum) && $stable(last) &&
                               $stable(out_row) && $stable(out_col))
    else $error("stalled result changed");

  // Each result is computed on its own; none follows a transfer at once
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result appeared right after a transfer");

  // Nothing follows the final element of C in the next cycle
  a_last_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid)
    else $error("result directly after the final element");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (.*);

`default_nettype wire
